FILE: hdl/mbcf_pkg.sv
// Shared types and constants for the multibyte character unit framer.
// No dependencies; used by mbcf_decode and multibyte_char_unit_framer.
package mbcf_pkg;

  // Encoding selection held in the mode register
  typedef enum logic [1:0] {
    ENC_SINGLE = 2'd0,
    ENC_SJIS   = 2'd1,
    ENC_UTF8   = 2'd2,
    ENC_UTF16  = 2'd3
  } mode_e;

  localparam mode_e MODE_RESET = ENC_UTF8;

  localparam logic [7:0] QMARK = 8'h3f;

  // Output queue sizing
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // One result transaction
  typedef struct packed {
    logic [31:0] char_value;
    logic [2:0]  unit_bytes;
    logic        invalid_lead;
    logic        end_marker;
    logic        last_result;
  } result_t;

  // Partial unit state
  typedef struct packed {
    logic [31:0] pending_value;
    logic [1:0]  bytes_remaining;
    logic [2:0]  bytes_taken;
  } unit_t;

  // Decoder outputs: up to two results plus the next unit state
  typedef struct packed {
    result_t     res0;
    result_t     res1;
    logic [1:0]  num_results;
    unit_t       unit_next;
  } decode_t;

endpackage

FILE: hdl/multibyte_char_unit_framer.sv
// Top level of the multibyte character unit framer: mode register, unit
// state, decoder and a small result queue. Depends on mbcf_pkg, mbcf_decode.
// Results are queued as their byte is taken; the queue head drives the outputs.
// Throughput: one byte per cycle; a zero byte closing a partial unit queues two
// results, and input stalls only while the 4-entry result queue lacks room for two.
// Reset: mode returns to UTF-8, unit state and queue are cleared.
module multibyte_char_unit_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] char_value_o,
  output logic [2:0]  unit_bytes_o,
  output logic        invalid_lead_o,
  output logic        end_marker_o,
  output logic        last_result_o
);

  localparam logic [mbcf_pkg::CNT_W-1:0] CNT_LIMIT =
    mbcf_pkg::CNT_W'(mbcf_pkg::FIFO_DEPTH - 2);

  mbcf_pkg::mode_e   mode_q;
  mbcf_pkg::unit_t   unit_q, unit_d;
  mbcf_pkg::decode_t dec;

  mbcf_pkg::result_t                 fifo_mem [mbcf_pkg::FIFO_DEPTH];
  logic [mbcf_pkg::PTR_W-1:0]        wr_ptr_q, wr_ptr_d, wr_ptr_nx;
  logic [mbcf_pkg::PTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [mbcf_pkg::CNT_W-1:0]        count_q, count_d;
  logic                              in_fire, out_fire;
  logic [1:0]                        push_num;

  mbcf_decode u_decode (
    .mode_i    (mode_q),
    .byte_in_i (byte_in_i),
    .unit_i    (unit_q),
    .dec_o     (dec)
  );

  // handshake
  assign in_stall_o  = (count_q > CNT_LIMIT);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != '0);
  assign out_fire    = out_valid_o && !out_stall_i;
  assign push_num    = in_fire ? dec.num_results : 2'd0;

  // unit state next value; a mode write discards a partial unit
  always_comb begin
    unit_d = unit_q;
    if (cfg_we_i) begin
      unit_d = '0;
    end else if (in_fire) begin
      unit_d = dec.unit_next;
    end
  end

  // queue pointers
  assign wr_ptr_nx = wr_ptr_q + mbcf_pkg::PTR_W'(1);
  assign wr_ptr_d  = wr_ptr_q + mbcf_pkg::PTR_W'(push_num);
  assign rd_ptr_d  = out_fire ? rd_ptr_q + mbcf_pkg::PTR_W'(1) : rd_ptr_q;
  assign count_d   = count_q + mbcf_pkg::CNT_W'(push_num)
                     - mbcf_pkg::CNT_W'(out_fire);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= mbcf_pkg::MODE_RESET;
      unit_q   <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= mbcf_pkg::mode_e'(cfg_wdata_i);
      end
      unit_q   <= unit_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (push_num != 2'd0) begin
      fifo_mem[wr_ptr_q] <= dec.res0;
    end
    if (push_num == 2'd2) begin
      fifo_mem[wr_ptr_nx] <= dec.res1;
    end
  end

  // head of queue drives the outputs
  assign char_value_o   = fifo_mem[rd_ptr_q].char_value;
  assign unit_bytes_o   = fifo_mem[rd_ptr_q].unit_bytes;
  assign invalid_lead_o = fifo_mem[rd_ptr_q].invalid_lead;
  assign end_marker_o   = fifo_mem[rd_ptr_q].end_marker;
  assign last_result_o  = fifo_mem[rd_ptr_q].last_result;

endmodule

FILE: hdl/mbcf_decode.sv
// Combinational byte decoder: frames one byte against the partial unit state.
// Depends on mbcf_pkg.
module mbcf_decode (
  input  mbcf_pkg::mode_e   mode_i,
  input  logic [7:0]        byte_in_i,
  input  mbcf_pkg::unit_t   unit_i,
  output mbcf_pkg::decode_t dec_o
);

  mbcf_pkg::result_t r0;
  mbcf_pkg::result_t r1;
  mbcf_pkg::unit_t   nxt;
  logic [1:0]        num;
  logic [31:0]       shifted;
  logic [2:0]        taken_inc;
  logic [1:0]        rem_dec;

  assign shifted   = {unit_i.pending_value[23:0], byte_in_i};
  assign taken_inc = unit_i.bytes_taken + 3'd1;
  assign rem_dec   = unit_i.bytes_remaining - 2'd1;

  always_comb begin
    r0  = '0;
    r1  = '0;
    nxt = unit_i;
    num = 2'd0;
    // default single-result form: the byte itself, one byte
    r0.char_value  = {24'b0, byte_in_i};
    r0.unit_bytes  = 3'd1;
    r0.last_result = 1'b1;

    if (byte_in_i == 8'd0) begin
      // end of string: flush any partial unit, then the end marker
      nxt = '0;
      r1  = '0;
      r1.end_marker  = 1'b1;
      r1.last_result = 1'b1;
      if (unit_i.bytes_taken != 3'd0) begin
        r0.char_value  = unit_i.pending_value;
        r0.unit_bytes  = unit_i.bytes_taken;
        r0.last_result = 1'b0;
        num = 2'd2;
      end else begin
        r0  = r1;
        num = 2'd1;
      end
    end else begin
      unique case (mode_i)
        mbcf_pkg::ENC_SINGLE: begin
          num = 2'd1;
        end
        mbcf_pkg::ENC_SJIS: begin
          if (unit_i.bytes_taken != 3'd0) begin
            r0.char_value = shifted;
            r0.unit_bytes = 3'd2;
            nxt = '0;
            num = 2'd1;
          end else if (byte_in_i[7]) begin
            nxt.pending_value   = {24'b0, byte_in_i};
            nxt.bytes_remaining = 2'd1;
            nxt.bytes_taken     = 3'd1;
          end else begin
            num = 2'd1;
          end
        end
        mbcf_pkg::ENC_UTF8: begin
          if (unit_i.bytes_remaining != 2'd0) begin
            // trail byte, shifted in unchecked
            if (rem_dec == 2'd0) begin
              r0.char_value = shifted;
              r0.unit_bytes = taken_inc;
              nxt = '0;
              num = 2'd1;
            end else begin
              nxt.pending_value   = shifted;
              nxt.bytes_taken     = taken_inc;
              nxt.bytes_remaining = rem_dec;
            end
          end else if (!byte_in_i[7]) begin
            num = 2'd1;
          end else if ((byte_in_i & 8'he0) == 8'hc0 ||
                       (byte_in_i & 8'hf0) == 8'he0 ||
                       (byte_in_i & 8'hf8) == 8'hf0) begin
            // valid lead byte opens a unit
            nxt.pending_value = {24'b0, byte_in_i};
            nxt.bytes_taken   = 3'd1;
            if ((byte_in_i & 8'he0) == 8'hc0) begin
              nxt.bytes_remaining = 2'd1;
            end else if ((byte_in_i & 8'hf0) == 8'he0) begin
              nxt.bytes_remaining = 2'd2;
            end else begin
              nxt.bytes_remaining = 2'd3;
            end
          end else begin
            // stray continuation or bad lead
            r0.char_value   = {24'b0, mbcf_pkg::QMARK};
            r0.invalid_lead = 1'b1;
            num = 2'd1;
          end
        end
        mbcf_pkg::ENC_UTF16: begin
          if (unit_i.bytes_taken != 3'd0) begin
            r0.char_value = {16'b0, byte_in_i, unit_i.pending_value[7:0]};
            r0.unit_bytes = 3'd2;
            nxt = '0;
            num = 2'd1;
          end else begin
            nxt.pending_value   = {24'b0, byte_in_i};
            nxt.bytes_remaining = 2'd1;
            nxt.bytes_taken     = 3'd1;
          end
        end
        default: begin
          num = 2'd1;
        end
      endcase
    end
  end

  assign dec_o.res0        = r0;
  assign dec_o.res1        = r1;
  assign dec_o.num_results = num;
  assign dec_o.unit_next   = nxt;

endmodule
